@@ hdl/scc_pkg.sv @@
package scc_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int RADIUS_W      = 31;

    typedef struct packed {
        logic signed [COORD_W-1:0]  other_x;
        logic signed [COORD_W-1:0]  other_y;
        logic signed [COORD_W-1:0]  other_z;
        logic        [RADIUS_W-1:0] other_radius;
        logic signed [COORD_W-1:0]  mover_x;
        logic signed [COORD_W-1:0]  mover_y;
        logic signed [COORD_W-1:0]  mover_z;
        logic        [RADIUS_W-1:0] mover_radius;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [COORD_W-1:0]  end_z;
        logic                       mover_is_projectile;
    } t_req;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic signed [COORD_W-1:0] hit_z;
    } t_rsp;

endpackage

@@ hdl/scc_stream_if.sv @@
interface scc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/scc_sqrt.sv @@
module scc_sqrt #(
    parameter int IN_W   = 66,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1,
    localparam int OUT_W = IN_W / 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [LANES-1:0][IN_W-1:0]        i_rad,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [LANES-1:0][OUT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]                 o_side
);

    logic [LANES-1:0][IN_W-1:0]  r_rem   [OUT_W];
    logic [LANES-1:0][OUT_W-1:0] r_res   [OUT_W];
    logic [SIDE_W-1:0]           r_side  [OUT_W];
    logic [OUT_W-1:0]            r_valid;

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        localparam int B = OUT_W - 1 - k;
        logic [LANES-1:0][IN_W-1:0]  rem_in, n_rem, trial;
        logic [LANES-1:0][OUT_W-1:0] res_in, n_res;
        logic [SIDE_W-1:0]           side_in;
        logic                        valid_in;

        if (k == 0) begin : g_first
            assign rem_in   = i_rad;
            assign res_in   = '0;
            assign side_in  = i_side;
            assign valid_in = i_valid;
        end else begin : g_next
            assign rem_in   = r_rem[k-1];
            assign res_in   = r_res[k-1];
            assign side_in  = r_side[k-1];
            assign valid_in = r_valid[k-1];
        end

        // Root bit B is set when (res + 2^B)^2 still fits under the radicand.
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = (IN_W'(res_in[l]) << (B + 1)) | (IN_W'(1) << (2 * B));
                if (rem_in[l] >= trial[l]) begin
                    n_rem[l] = rem_in[l] - trial[l];
                    n_res[l] = res_in[l] | (OUT_W'(1) << B);
                end else begin
                    n_rem[l] = rem_in[l];
                    n_res[l] = res_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[k]  <= n_res;
                r_side[k] <= side_in;
            end
        end

        if (k < OUT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                end
            end
        end
    end

    assign o_valid = r_valid[OUT_W-1];
    assign o_root  = r_res[OUT_W-1];
    assign o_side  = r_side[OUT_W-1];

endmodule

@@ hdl/scc_div.sv @@
module scc_div #(
    parameter int DEN_W  = 33,
    parameter int Q_W    = 17,
    parameter int LANES  = 2,
    parameter int SIDE_W = 1,
    localparam int NUM_W = DEN_W + Q_W - 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]              i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][Q_W-1:0]     o_quo,
    output logic [SIDE_W-1:0]             o_side
);

    logic [LANES-1:0][NUM_W-1:0] r_rem   [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_quo   [Q_W];
    logic [DEN_W-1:0]            r_den   [Q_W];
    logic [SIDE_W-1:0]           r_side  [Q_W];
    logic [Q_W-1:0]              r_valid;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;
        logic [LANES-1:0][NUM_W-1:0] rem_in, n_rem;
        logic [LANES-1:0][Q_W-1:0]   quo_in, n_quo;
        logic [NUM_W-1:0]            trial;
        logic [DEN_W-1:0]            den_in;
        logic [SIDE_W-1:0]           side_in;
        logic                        valid_in;

        if (k == 0) begin : g_first
            assign rem_in   = i_num;
            assign quo_in   = '0;
            assign den_in   = i_den;
            assign side_in  = i_side;
            assign valid_in = i_valid;
        end else begin : g_next
            assign rem_in   = r_rem[k-1];
            assign quo_in   = r_quo[k-1];
            assign den_in   = r_den[k-1];
            assign side_in  = r_side[k-1];
            assign valid_in = r_valid[k-1];
        end

        assign trial = NUM_W'(den_in) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (rem_in[l] >= trial) begin
                    n_rem[l] = rem_in[l] - trial;
                    n_quo[l] = quo_in[l] | (Q_W'(1) << B);
                end else begin
                    n_rem[l] = rem_in[l];
                    n_quo[l] = quo_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end

        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_valid = r_valid[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_side  = r_side[Q_W-1];

endmodule

@@ hdl/swept_circle_collision_check.sv @@
// Swept circle against stationary circle test in signed fixed point with FRAC_BITS fraction
// bits. Every request yields one response: a hit flag and the mover's centre at first
// contact (the centres' midpoint for a projectile starting on the target's centre), or
// all zeros on a miss. The block takes one request per clock while the output is not
// stalled and returns responses in order, through two bit-per-stage square root pipelines
// (33 and 36 stages) and a bit-per-stage divider of FRAC_BITS + 1 stages. A one-entry
// input buffer takes one more request while a finished response waits at the output.
module swept_circle_collision_check
    import scc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    scc_stream_if.sink   i_req,
    scc_stream_if.source o_rsp
);

    localparam int C_W   = COORD_W;
    localparam int R_W   = C_W;
    localparam int BX_W  = C_W + 2;
    localparam int N_W   = C_W + 1;
    localparam int SQ_W  = 2 * N_W;
    localparam int L_W   = SQ_W / 2;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int U_W   = FRAC_BITS + 2;
    localparam int P_W   = U_W + N_W;
    localparam int D_W   = P_W + 1 - FRAC_BITS;
    localparam int D2_W  = 2 * (D_W - 1);
    localparam int S_W   = 2 * D_W;
    localparam int RT_W  = S_W / 2;
    localparam int DI_W  = RT_W + 2;
    localparam int M_W   = U_W + DI_W;
    localparam int H_W   = M_W - FRAC_BITS;
    localparam int NUM_W = L_W + Q_W - 1;

    localparam logic signed [H_W:0] SAT_HI = (H_W+1)'($signed({1'b0, {(C_W-1){1'b1}}}));
    localparam logic signed [H_W:0] SAT_LO = (H_W+1)'($signed({1'b1, {(C_W-1){1'b0}}}));

    typedef struct packed {
        logic                    rej_box;
        logic                    proj;
        logic signed [C_W-1:0]   mx;
        logic signed [C_W-1:0]   my;
        logic signed [C_W-1:0]   mz;
        logic signed [C_W-1:0]   midx;
        logic signed [C_W-1:0]   midy;
        logic signed [C_W-1:0]   midz;
        logic        [R_W-1:0]   r;
        logic signed [N_W-1:0]   cx;
        logic signed [N_W-1:0]   cy;
        logic signed [N_W-1:0]   nx;
        logic signed [N_W-1:0]   ny;
        logic        [L_W-1:0]   ln;
        logic        [L_W-1:0]   lc;
        logic signed [U_W-1:0]   ux;
        logic signed [U_W-1:0]   uy;
        logic                    too_far;
        logic signed [D_W-1:0]   d;
        logic                    d_pos;
        logic                    wide_ok;
        logic signed [DI_W-1:0]  travel;
        logic                    too_short;
    } t_ctx;

    localparam int CTX_W = $bits(t_ctx);

    function automatic logic [N_W-1:0] f_mag(input logic signed [N_W-1:0] v);
        return v[N_W-1] ? N_W'(-v) : N_W'(v);
    endfunction

    function automatic logic signed [C_W-1:0] f_sat(input logic signed [H_W:0] v);
        logic signed [H_W:0] t;
        t = v;
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return C_W'(t);
    endfunction

    function automatic logic signed [C_W-1:0] f_mid(input logic signed [C_W-1:0] a,
                                                   input logic signed [C_W-1:0] b);
        logic [N_W-1:0] s;
        s = N_W'(a) + N_W'(b);
        s = s + {{(N_W-1){1'b0}}, s[N_W-1]};
        return s[N_W-1:1];
    endfunction

    // Input buffer and flow control.
    logic en, acc, pv;
    t_req preq;
    t_req r_skid;
    logic r_skid_v;
    logic r_out_v;

    assign en          = !r_out_v || o_rsp.ready;
    assign i_req.ready = !r_skid_v;
    assign acc         = i_req.valid && !r_skid_v;
    assign pv          = r_skid_v || i_req.valid;
    assign preq        = r_skid_v ? r_skid : i_req.payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (en) begin
            r_skid_v <= 1'b0;
        end else if (acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !en) begin
            r_skid <= i_req.payload;
        end
    end

    // Stage 1: box test, differences, midpoint.
    t_ctx n_ctx1, r1_ctx;
    logic signed [N_W-1:0] n_nz1, r1_nz;
    logic signed [BX_W-1:0] rr, lo_x, hi_x, lo_y, hi_y;
    logic r1_v;

    always_comb begin
        n_ctx1      = '0;
        n_ctx1.r    = R_W'(preq.other_radius) + R_W'(preq.mover_radius);
        rr          = $signed({2'b00, n_ctx1.r});
        lo_x = (preq.mover_x < preq.end_x) ? BX_W'(preq.mover_x) : BX_W'(preq.end_x);
        hi_x = (preq.mover_x > preq.end_x) ? BX_W'(preq.mover_x) : BX_W'(preq.end_x);
        lo_y = (preq.mover_y < preq.end_y) ? BX_W'(preq.mover_y) : BX_W'(preq.end_y);
        hi_y = (preq.mover_y > preq.end_y) ? BX_W'(preq.mover_y) : BX_W'(preq.end_y);
        n_ctx1.rej_box = (BX_W'(preq.other_x) < lo_x - rr) ||
                         (BX_W'(preq.other_x) > hi_x + rr) ||
                         (BX_W'(preq.other_y) < lo_y - rr) ||
                         (BX_W'(preq.other_y) > hi_y + rr);
        n_ctx1.proj = preq.mover_is_projectile;
        n_ctx1.mx   = preq.mover_x;
        n_ctx1.my   = preq.mover_y;
        n_ctx1.mz   = preq.mover_z;
        n_ctx1.midx = f_mid(preq.other_x, preq.mover_x);
        n_ctx1.midy = f_mid(preq.other_y, preq.mover_y);
        n_ctx1.midz = f_mid(preq.other_z, preq.mover_z);
        n_ctx1.nx   = N_W'(preq.end_x) - N_W'(preq.mover_x);
        n_ctx1.ny   = N_W'(preq.end_y) - N_W'(preq.mover_y);
        n_ctx1.cx   = N_W'(preq.other_x) - N_W'(preq.mover_x);
        n_ctx1.cy   = N_W'(preq.other_y) - N_W'(preq.mover_y);
        n_nz1       = N_W'(preq.end_z) - N_W'(preq.mover_z);
    end

    // Stage 2: squares. Stage 3: sums of squares.
    t_ctx r2_ctx, r3_ctx;
    logic [SQ_W-1:0] r2_nx2, r2_ny2, r2_nz2, r2_cx2, r2_cy2;
    logic [SQ_W-1:0] r3_nsum, r3_csum;
    logic r2_v, r3_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctx  <= n_ctx1;
            r1_nz   <= n_nz1;
            r2_ctx  <= r1_ctx;
            r2_nx2  <= SQ_W'(f_mag(r1_ctx.nx)) * SQ_W'(f_mag(r1_ctx.nx));
            r2_ny2  <= SQ_W'(f_mag(r1_ctx.ny)) * SQ_W'(f_mag(r1_ctx.ny));
            r2_nz2  <= SQ_W'(f_mag(r1_nz)) * SQ_W'(f_mag(r1_nz));
            r2_cx2  <= SQ_W'(f_mag(r1_ctx.cx)) * SQ_W'(f_mag(r1_ctx.cx));
            r2_cy2  <= SQ_W'(f_mag(r1_ctx.cy)) * SQ_W'(f_mag(r1_ctx.cy));
            r3_ctx  <= r2_ctx;
            r3_nsum <= r2_nx2 + r2_ny2 + r2_nz2;
            r3_csum <= r2_cx2 + r2_cy2;
        end
    end

    // Lengths of motion and of centre offset.
    logic                        sa_v;
    logic [1:0][L_W-1:0]         sa_root;
    logic [CTX_W-1:0]            sa_side;
    t_ctx                        ctx_a;

    scc_sqrt #(
        .IN_W   (SQ_W),
        .LANES  (2),
        .SIDE_W (CTX_W)
    ) u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_v),
        .i_rad   ({r3_csum, r3_nsum}),
        .i_side  (r3_ctx),
        .o_valid (sa_v),
        .o_root  (sa_root),
        .o_side  (sa_side)
    );

    always_comb begin
        ctx_a    = t_ctx'(sa_side);
        ctx_a.ln = sa_root[0];
        ctx_a.lc = sa_root[1];
    end

    // Unit direction magnitudes.
    logic                  dv_v;
    logic [1:0][Q_W-1:0]   dv_quo;
    logic [CTX_W-1:0]      dv_side;

    scc_div #(
        .DEN_W  (L_W),
        .Q_W    (Q_W),
        .LANES  (2),
        .SIDE_W (CTX_W)
    ) u_div_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sa_v),
        .i_num   ({NUM_W'(f_mag(ctx_a.ny)) << FRAC_BITS,
                   NUM_W'(f_mag(ctx_a.nx)) << FRAC_BITS}),
        .i_den   (ctx_a.ln),
        .i_side  (ctx_a),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Stage 5: signed direction, reach test.
    t_ctx n_ctx5, r5_ctx;
    logic r5_v;

    always_comb begin
        n_ctx5    = t_ctx'(dv_side);
        n_ctx5.ux = n_ctx5.nx[N_W-1] ? -U_W'(dv_quo[0]) : U_W'(dv_quo[0]);
        n_ctx5.uy = n_ctx5.ny[N_W-1] ? -U_W'(dv_quo[1]) : U_W'(dv_quo[1]);
        n_ctx5.too_far = ((L_W+1)'(n_ctx5.ln) + (L_W+1)'(n_ctx5.r)) <
                         (L_W+1)'(n_ctx5.lc);
    end

    // Stage 6: projections. Stage 7: D. Stage 8: squares for the pass test.
    t_ctx r6_ctx, n_ctx7, r7_ctx, n_ctx8, r8_ctx;
    logic signed [P_W-1:0] r6_px, r6_py;
    logic signed [P_W:0]   dsum;
    logic [D2_W-1:0]       r8_d2;
    logic [2*R_W-1:0]      r8_r2;
    logic [SQ_W-1:0]       r8_lcsq;
    logic r6_v, r7_v, r8_v;

    assign dsum = (P_W+1)'(r6_px) + (P_W+1)'(r6_py);

    always_comb begin
        n_ctx7   = r6_ctx;
        n_ctx7.d = D_W'(dsum >>> FRAC_BITS);
    end

    always_comb begin
        n_ctx8       = r7_ctx;
        n_ctx8.d_pos = !r7_ctx.d[D_W-1] && (r7_ctx.d != '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_ctx   <= n_ctx5;
            r6_ctx   <= r5_ctx;
            r6_px    <= P_W'(r5_ctx.ux) * P_W'(r5_ctx.cx);
            r6_py    <= P_W'(r5_ctx.uy) * P_W'(r5_ctx.cy);
            r7_ctx   <= n_ctx7;
            r8_ctx   <= n_ctx8;
            r8_d2    <= D2_W'(r7_ctx.d[D_W-2:0]) * D2_W'(r7_ctx.d[D_W-2:0]);
            r8_r2    <= (2*R_W)'(r7_ctx.r) * (2*R_W)'(r7_ctx.r);
            r8_lcsq  <= SQ_W'(r7_ctx.lc) * SQ_W'(r7_ctx.lc);
        end
    end

    // Stage 9: T = R^2 + D^2 - |C|^2.
    t_ctx n_ctx9, r9_ctx;
    logic [S_W-1:0] ssum, r9_t;
    logic r9_v;

    assign ssum = S_W'(r8_r2) + S_W'(r8_d2);

    always_comb begin
        n_ctx9         = r8_ctx;
        n_ctx9.wide_ok = ssum > S_W'(r8_lcsq);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_ctx <= n_ctx9;
            r9_t   <= ssum - S_W'(r8_lcsq);
        end
    end

    logic                  sc_v;
    logic [0:0][RT_W-1:0]  sc_root;
    logic [CTX_W-1:0]      sc_side;

    scc_sqrt #(
        .IN_W   (S_W),
        .LANES  (1),
        .SIDE_W (CTX_W)
    ) u_sqrt_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_rad   (r9_t),
        .i_side  (r9_ctx),
        .o_valid (sc_v),
        .o_root  (sc_root),
        .o_side  (sc_side)
    );

    // Stage 10: travel distance. Stage 11: offset along the motion.
    t_ctx n_ctx10, r10_ctx, r11_ctx;
    logic signed [M_W-1:0] r11_qx, r11_qy;
    logic r10_v, r11_v;

    always_comb begin
        n_ctx10           = t_ctx'(sc_side);
        n_ctx10.travel    = DI_W'(n_ctx10.d) - $signed({2'b00, sc_root[0]});
        n_ctx10.too_short = $signed(DI_W'(n_ctx10.ln)) < n_ctx10.travel;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_ctx <= n_ctx10;
            r11_ctx <= r10_ctx;
            r11_qx  <= M_W'(r10_ctx.ux) * M_W'(r10_ctx.travel);
            r11_qy  <= M_W'(r10_ctx.uy) * M_W'(r10_ctx.travel);
        end
    end

    // Output stage.
    t_rsp n_rsp, r_rsp;
    logic signed [H_W:0] hx_w, hy_w;
    logic hit_mid, hit_main;

    always_comb begin
        hx_w = (H_W+1)'(r11_qx >>> FRAC_BITS) + (H_W+1)'(r11_ctx.mx);
        hy_w = (H_W+1)'(r11_qy >>> FRAC_BITS) + (H_W+1)'(r11_ctx.my);
        hit_mid  = !r11_ctx.rej_box && (r11_ctx.ln != '0) && (r11_ctx.lc == '0) &&
                   r11_ctx.proj;
        hit_main = !r11_ctx.rej_box && (r11_ctx.ln != '0) && (r11_ctx.lc != '0) &&
                   !r11_ctx.too_far && r11_ctx.d_pos && r11_ctx.wide_ok &&
                   !r11_ctx.too_short;
        n_rsp = '0;
        if (hit_mid) begin
            n_rsp.hit   = 1'b1;
            n_rsp.hit_x = r11_ctx.midx;
            n_rsp.hit_y = r11_ctx.midy;
            n_rsp.hit_z = r11_ctx.midz;
        end else if (hit_main) begin
            n_rsp.hit   = 1'b1;
            n_rsp.hit_x = f_sat(hx_w);
            n_rsp.hit_y = f_sat(hy_w);
            n_rsp.hit_z = r11_ctx.mz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r5_v    <= 1'b0;
            r6_v    <= 1'b0;
            r7_v    <= 1'b0;
            r8_v    <= 1'b0;
            r9_v    <= 1'b0;
            r10_v   <= 1'b0;
            r11_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r1_v    <= pv;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r5_v    <= dv_v;
            r6_v    <= r5_v;
            r7_v    <= r6_v;
            r8_v    <= r7_v;
            r9_v    <= r8_v;
            r10_v   <= sc_v;
            r11_v   <= r10_v;
            r_out_v <= r11_v;
        end
    end

    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_rsp;

`ifndef NO_ASSERTIONS
    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.payload.hit |->
            o_rsp.payload.hit_x == '0 && o_rsp.payload.hit_y == '0 &&
            o_rsp.payload.hit_z == '0)
        else $error("Miss response carries a nonzero position.");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(o_rsp.valid && !o_rsp.ready))
        else $error("Input buffer filled while the pipeline was free to advance.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("Response valid right after reset.");
`endif

endmodule

@@ tb/scc_collision_checker.sv @@
module scc_collision_checker
    import scc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    scc_stream_if req_ch,
    scc_stream_if rsp_ch,
    output int    o_errors,
    output int    o_pending,
    output int    o_checked,
    output int    o_hits
);

    localparam int FRAC = FRAC_BITS_DEF;

    t_rsp contact_q[$];
    int   err_cnt = 0;
    int   chk_cnt = 0;
    int   hit_cnt = 0;

    function automatic logic [127:0] square_wide(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    function automatic longint isqrt_wide(logic [127:0] v);
        logic [127:0] res;
        logic [127:0] cand;
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (128'd1 << b);
            if (cand * cand <= v) begin
                res = cand;
            end
        end
        return longint'(res[63:0]);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sh7FFF_FFFF) begin
            return 64'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            return -64'sh8000_0000;
        end
        return v;
    endfunction

    function automatic t_rsp predict_contact(t_req q);
        longint ox, oy, oz, mx, my, mz, ex, ey, ez, r;
        longint lo_x, hi_x, lo_y, hi_y, nx, ny, nz, ln, cx, cy, lc, ux, uy, d, travel;
        logic [127:0] lcsq, s;
        t_rsp p;
        p = '0;
        ox = longint'($signed(q.other_x));
        oy = longint'($signed(q.other_y));
        oz = longint'($signed(q.other_z));
        mx = longint'($signed(q.mover_x));
        my = longint'($signed(q.mover_y));
        mz = longint'($signed(q.mover_z));
        ex = longint'($signed(q.end_x));
        ey = longint'($signed(q.end_y));
        ez = longint'($signed(q.end_z));
        r = longint'({1'b0, q.other_radius}) + longint'({1'b0, q.mover_radius});
        lo_x = ((mx < ex) ? mx : ex) - r;
        hi_x = ((mx > ex) ? mx : ex) + r;
        lo_y = ((my < ey) ? my : ey) - r;
        hi_y = ((my > ey) ? my : ey) + r;
        if (ox < lo_x || ox > hi_x || oy < lo_y || oy > hi_y) begin
            return p;
        end
        nx = ex - mx;
        ny = ey - my;
        nz = ez - mz;
        ln = isqrt_wide(square_wide(nx) + square_wide(ny) + square_wide(nz));
        if (ln == 0) begin
            return p;
        end
        cx = ox - mx;
        cy = oy - my;
        lc = isqrt_wide(square_wide(cx) + square_wide(cy));
        if (lc == 0) begin
            if (q.mover_is_projectile) begin
                p.hit = 1'b1;
                p.hit_x = 32'((ox + mx) / 2);
                p.hit_y = 32'((oy + my) / 2);
                p.hit_z = 32'((oz + mz) / 2);
            end
            return p;
        end
        if (ln + r < lc) begin
            return p;
        end
        ux = (nx <<< FRAC) / ln;
        uy = (ny <<< FRAC) / ln;
        d = (ux * cx + uy * cy) >>> FRAC;
        if (d <= 0) begin
            return p;
        end
        lcsq = square_wide(lc);
        s = square_wide(r) + square_wide(d);
        if (s <= lcsq) begin
            return p;
        end
        travel = d - isqrt_wide(s - lcsq);
        if (ln < travel) begin
            return p;
        end
        p.hit = 1'b1;
        p.hit_x = 32'(clamp32(((ux * travel) >>> FRAC) + mx));
        p.hit_y = 32'(clamp32(((uy * travel) >>> FRAC) + my));
        p.hit_z = q.mover_z;
        return p;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on response %0d: %s is %0h, expected %0h",
                 chk_cnt, what, got, want);
        err_cnt++;
    endtask

    assign o_errors  = err_cnt;
    assign o_checked = chk_cnt;
    assign o_hits    = hit_cnt;
    assign o_pending = contact_q.size();

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                contact_q.push_back(predict_contact(req_ch.payload));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (contact_q.size() == 0) begin
                    report_mismatch("unexpected response", got.hit, 0);
                end else begin
                    want = contact_q.pop_front();
                    if (got.hit !== want.hit) report_mismatch("hit", got.hit, want.hit);
                    if (got.hit_x !== want.hit_x) report_mismatch("hit_x", got.hit_x, want.hit_x);
                    if (got.hit_y !== want.hit_y) report_mismatch("hit_y", got.hit_y, want.hit_y);
                    if (got.hit_z !== want.hit_z) report_mismatch("hit_z", got.hit_z, want.hit_z);
                    if (want.hit) hit_cnt++;
                end
                chk_cnt++;
            end
        end
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import scc_pkg::*;

    localparam int N_RANDOM = 1750;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, checked, hits;

    scc_stream_if #(.T(t_req)) req_ch ();
    scc_stream_if #(.T(t_rsp)) rsp_ch ();

    swept_circle_collision_check u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    scc_collision_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_hits    (hits)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // The receiver switches between stall patterns, each held for a random stretch of time.
    int stall_mode = 0;
    int mode_left = 0;
    int phase_cnt = 0;
    initial rsp_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        phase_cnt++;
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
            default: rsp_ch.ready <= (phase_cnt % 7) < 4;
        endcase
    end

    function automatic longint spread(int sc);
        longint span;
        span = longint'(1) << sc;
        return longint'($urandom_range(0, 32'(2 * span))) - span;
    endfunction

    function automatic t_req build_request(longint ox, longint oy, longint oz, longint orad,
                                           longint mx, longint my, longint mz, longint mrad,
                                           longint ex, longint ey, longint ez, bit proj);
        t_req q;
        q.other_x = 32'(ox);
        q.other_y = 32'(oy);
        q.other_z = 32'(oz);
        q.other_radius = 31'(orad);
        q.mover_x = 32'(mx);
        q.mover_y = 32'(my);
        q.mover_z = 32'(mz);
        q.mover_radius = 31'(mrad);
        q.end_x = 32'(ex);
        q.end_y = 32'(ey);
        q.end_z = 32'(ez);
        q.mover_is_projectile = proj;
        return q;
    endfunction

    function automatic t_req random_request();
        int kind, sc, frac;
        longint mx, my, mz, ex, ey, ez, ox, oy;
        kind = $urandom_range(0, 99);
        sc = $urandom_range(8, 26);
        mx = longint'($signed($urandom)) >>> 2;
        my = longint'($signed($urandom)) >>> 2;
        mz = spread(sc);
        ex = mx + spread(sc);
        ey = my + spread(sc);
        ez = ($urandom_range(0, 1) == 1) ? mz : mz + spread(sc - 1);
        frac = $urandom_range(0, 300);
        ox = mx + ((ex - mx) * frac) / 256 + spread(sc - 2);
        oy = my + ((ey - my) * frac) / 256 + spread(sc - 2);
        if (kind < 10) begin
            return build_request($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom_range(0, 1));
        end else if (kind < 16) begin
            ox = mx;
            oy = my;
        end else if (kind < 20) begin
            ex = mx;
            ey = my;
            if ($urandom_range(0, 1) == 1) ez = mz;
        end
        return build_request(ox, oy, $urandom, $urandom_range(0, 32'(1) << sc), mx, my, mz,
                             $urandom_range(0, 32'(1) << sc), ex, ey, ez,
                             $urandom_range(0, 1));
    endfunction

    task automatic push_request(t_req q);
        req_ch.valid = 1'b1;
        req_ch.payload = q;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int cycles);
        req_ch.valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    localparam longint MAXC = 64'sh7FFF_FFFF;
    localparam longint MINC = -64'sh8000_0000;
    localparam longint MAXR = 64'sh7FFF_FFFF;
    localparam longint ONE = 64'sh1_0000;

    initial begin
        t_req directed[$];
        int burst;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed.push_back(build_request(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(build_request(MAXC, MAXC, MAXC, MAXR, MAXC, MAXC, MAXC, MAXR,
                                         MAXC, MAXC, MAXC, 1));
        directed.push_back(build_request(MINC, MINC, MINC, MAXR, MINC, MINC, MINC, MAXR,
                                         MAXC, MAXC, MAXC, 1));
        directed.push_back(build_request(MAXC, MINC, MAXC, MAXR, MINC, MAXC, MINC, MAXR,
                                         MAXC, MINC, MINC, 0));
        // Outside the grown box.
        directed.push_back(build_request(100 * ONE, 0, 0, ONE, 0, 0, 0, ONE,
                                         10 * ONE, 0, 0, 0));
        // No motion.
        directed.push_back(build_request(ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 1));
        // Motion along z only.
        directed.push_back(build_request(ONE, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 5 * ONE, 1));
        // Coincident centres, projectile and plain mover.
        directed.push_back(build_request(3 * ONE, -5 * ONE, 7, ONE, 3 * ONE, -5 * ONE, -2,
                                         ONE, 9 * ONE, 0, 0, 1));
        directed.push_back(build_request(3 * ONE, -5 * ONE, 7, ONE, 3 * ONE, -5 * ONE, -2,
                                         ONE, 9 * ONE, 0, 0, 0));
        directed.push_back(build_request(MINC, MINC, MINC, 0, MINC, MINC, -1, 0,
                                         MAXC, 0, 0, 1));
        // Too far away for the motion length.
        directed.push_back(build_request(20 * ONE, 20 * ONE, 0, ONE, 0, 0, 0, ONE,
                                         2 * ONE, 2 * ONE, 0, 0));
        // Moving away.
        directed.push_back(build_request(5 * ONE, 0, 0, ONE, 0, 0, 0, ONE,
                                         -10 * ONE, 0, 0, 0));
        // Passing wide of the target.
        directed.push_back(build_request(5 * ONE, 8 * ONE, 0, ONE, 0, 0, 0, ONE,
                                         20 * ONE, 0, 0, 0));
        // Head-on hit and a motion that stops short.
        directed.push_back(build_request(10 * ONE, 0, 0, ONE, 0, 0, 4, ONE,
                                         20 * ONE, 0, 0, 0));
        directed.push_back(build_request(10 * ONE, 0, 0, ONE, 0, 0, 4, ONE,
                                         3 * ONE, 0, 0, 0));
        directed.push_back(build_request(10 * ONE, ONE, 0, 2 * ONE, -ONE, 0, 0, ONE / 2,
                                         15 * ONE, 3 * ONE, 4 * ONE, 1));
        // The mover starts overlapping, and the contact saturates below and then above the range.
        directed.push_back(build_request(MINC + ONE, 0, 0, 64'sh4000_0000, MINC, 0, 0,
                                         64'sh4000_0000, MINC + 16 * ONE, 0, 0, 0));
        directed.push_back(build_request(MAXC - ONE, 0, 0, 64'sh4000_0000, MAXC, 0, 0,
                                         64'sh4000_0000, MAXC - 16 * ONE, 0, 0, 0));
        foreach (directed[k]) begin
            push_request(directed[k]);
        end

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                req_ch.valid = 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            if (burst == 0) begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
                burst = $urandom_range(1, 40);
            end
            push_request(random_request());
            burst--;
        end
        req_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        $display("Checked %0d responses, %0d of them hits, under varied sender gaps and stalls.",
                 checked, hits);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
